/* rtl/ght_pkg.sv */
// Package for the generational handle table: handle layout constants, opcode and
// status codes, configuration register indexes, and the request and response words.
// It has no dependencies. The top level imports it; the table RAM wrapper does not.
package ght_pkg;

  localparam int INDEX_BITS     = 20;
  localparam int HANDLE_BITS    = 32;
  localparam int TAG_BITS       = HANDLE_BITS - INDEX_BITS;
  localparam int USED_BITS      = 11;
  localparam int OPCODE_BITS    = 3;
  localparam int STATUS_BITS    = 2;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = TAG_BITS;
  localparam int WORD_DATA_BITS = 64;

  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int DEF_DATA_WIDTH  = 64;

  localparam logic [INDEX_BITS-1:0] COUNT_MAX = '1;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_REF_MODE = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TAG_SEED = 1'd1;

  typedef enum logic [OPCODE_BITS-1:0] {
    OP_NEW     = 3'd0,
    OP_DISPOSE = 3'd1,
    OP_GET     = 3'd2,
    OP_SET     = 3'd3,
    OP_ACQUIRE = 3'd4,
    OP_RELEASE = 3'd5,
    OP_CHECK   = 3'd6
  } op_t;

  typedef enum logic [STATUS_BITS-1:0] {
    STAT_OK        = 2'd0,
    STAT_INVALID   = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_SATURATED = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic [OPCODE_BITS-1:0]    opcode;
    logic [HANDLE_BITS-1:0]    handle_in;
    logic [WORD_DATA_BITS-1:0] data_in;
  } req_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0]    status;
    logic [HANDLE_BITS-1:0]    handle_out;
    logic [WORD_DATA_BITS-1:0] data_out;
    logic                      is_valid;
    logic [INDEX_BITS-1:0]     previous_count;
    logic [USED_BITS-1:0]      used_entries;
  } rsp_t;

endpackage

/* rtl/ght_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// Used for the entry store of the handle table; no package dependencies.
module ght_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/generational_handle_table.sv */
// Top level of the generational handle table: control, free list and result register.
// Depends on ght_pkg and on ght_ram, which holds the per-entry words.
//
// This block hands out 32-bit handles (entry index in bits 19..0, a nonzero
// generation tag in bits 31..20) and answers new, dispose, get, set, acquire,
// release and check requests against them. On acceptance the entry word is
// read from the single table RAM; in the execute state the tag and count are
// checked, the word is written back and the response word is loaded into the
// output register. That one read-modify-write per request through the RAM
// means no new request is taken until the last one is finished. The response
// register decouples the two channels, so a new request is taken while an
// earlier response still waits for its consumer; the block holds in the
// execute state only while the output register is still full and stalled.
// Each RAM word packs the free-list link, the tag and reference count, and the
// data. Entries at or above the high-water mark have never been written and
// are never looked at, so the table needs no clearing pass after reset and is
// ready in the first cycle. A freed entry carries tag zero, which no handle can
// match, so no separate live flag is stored. Configuration writes are meant to
// happen only while no request is in flight; writing the tag seed also reloads
// the rolling tag, with zero taken as one.
module generational_handle_table
  import ght_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int DATA_WIDTH  = DEF_DATA_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  req_t                      req,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output rsp_t                      rsp
);

  // Index into the table, and counters that must also hold TABLE_DEPTH itself.
  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = IDX_W + 1;
  localparam int CMP_W  = INDEX_BITS + 1;
  // RAM word layout, low to high: data, tag and count, free-list link.
  localparam int TC_LO  = DATA_WIDTH;
  localparam int NF_LO  = DATA_WIDTH + HANDLE_BITS;
  localparam int WORD_W = NF_LO + CNT_W;
  localparam logic [CNT_W-1:0] DEPTH_VAL = CNT_W'(TABLE_DEPTH);

  state_t state, state_next;

  // Configuration and table bookkeeping.
  logic                ref_mode;
  logic [TAG_BITS-1:0] next_tag, next_tag_next;
  logic [CNT_W-1:0]    free_head, free_head_next;
  logic [CNT_W-1:0]    high_water, high_water_next;
  logic [CNT_W-1:0]    live_count, live_count_next;

  // The request being worked on.
  req_t req_q;

  // RAM ports.
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [WORD_W-1:0] rd_word;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [WORD_W-1:0] wr_word;

  logic req_take;
  logic fire;
  rsp_t rsp_next;

  // Fields of the entry that was read and of the held request.
  logic [CNT_W-1:0]      e_link;
  logic [TAG_BITS-1:0]   e_tag;
  logic [INDEX_BITS-1:0] e_cnt;
  logic [DATA_WIDTH-1:0] e_data;
  logic [INDEX_BITS-1:0] h_idx;
  logic [TAG_BITS-1:0]   h_tag;
  logic [DATA_WIDTH-1:0] h_data;
  logic                  found;
  logic                  counted;
  logic [TAG_BITS-1:0]   tag_inc;

  ght_ram #(
    .WIDTH(WORD_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_word),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_word)
  );

  // A new request reads the entry at the head of the free list, since that
  // entry's link gives the next head; every other request reads its handle.
  always_comb begin
    if (req.opcode == OP_NEW) begin
      rd_addr = free_head[IDX_W-1:0];
    end else begin
      rd_addr = req.handle_in[IDX_W-1:0];
    end
  end

  assign e_link = rd_word[NF_LO +: CNT_W];
  assign e_tag  = rd_word[TC_LO + INDEX_BITS +: TAG_BITS];
  assign e_cnt  = rd_word[TC_LO +: INDEX_BITS];
  assign e_data = rd_word[0 +: DATA_WIDTH];
  assign h_idx  = req_q.handle_in[INDEX_BITS-1:0];
  assign h_tag  = req_q.handle_in[HANDLE_BITS-1:INDEX_BITS];
  assign h_data = req_q.data_in[DATA_WIDTH-1:0];

  // A handle is good when its index lies below the high-water mark and its
  // nonzero tag matches the stored one. Freed entries hold tag zero.
  assign found = ({1'b0, h_idx} < CMP_W'(high_water)) && (h_tag != '0) && (e_tag == h_tag);
  // Entries made while counting was off hold count zero and are refused by
  // count operations, and by get and set while counting is on.
  assign counted = ref_mode && found && (e_cnt != '0);

  assign tag_inc = next_tag + TAG_BITS'(1);

  // Sequencer: take a request when idle, finish it once the output register
  // can accept the response.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_stall  = 1'b1;
    req_take   = 1'b0;
    fire       = 1'b0;
    case (state)
      S_IDLE: begin
        // The input is held off while reset is applied, so no word is lost.
        req_stall = rst;
        if (req_valid && !rst) begin
          req_take   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!rsp_valid || !rsp_stall) begin
          fire       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign rd_en = req_take;

  // Operation logic for the execute state: entry update, bookkeeping and response.
  always_comb begin
    wr_en           = 1'b0;
    wr_addr         = h_idx[IDX_W-1:0];
    wr_word         = rd_word;
    free_head_next  = free_head;
    high_water_next = high_water;
    live_count_next = live_count;
    next_tag_next   = next_tag;
    rsp_next        = '0;
    rsp_next.status = STAT_INVALID;

    case (req_q.opcode)
      OP_NEW: begin
        if (free_head == DEPTH_VAL) begin
          rsp_next.status = STAT_FULL;
        end else begin
          // Entries above the high-water mark were never used and come in order;
          // below it the free list is followed through the stored link.
          if (free_head >= high_water) begin
            high_water_next = free_head + CNT_W'(1);
            free_head_next  = free_head + CNT_W'(1);
          end else begin
            free_head_next = e_link;
          end
          next_tag_next       = (tag_inc == '0) ? TAG_BITS'(1) : tag_inc;
          wr_en               = 1'b1;
          wr_addr             = free_head[IDX_W-1:0];
          wr_word             = {e_link, next_tag, INDEX_BITS'(ref_mode), h_data};
          live_count_next     = live_count + CNT_W'(1);
          rsp_next.handle_out = {next_tag, INDEX_BITS'(free_head)};
          rsp_next.status     = STAT_OK;
        end
      end
      OP_DISPOSE: begin
        if (found) begin
          rsp_next.data_out = WORD_DATA_BITS'(e_data);
          wr_en             = 1'b1;
          wr_word           = {free_head, {HANDLE_BITS{1'b0}}, {DATA_WIDTH{1'b0}}};
          live_count_next   = live_count - CNT_W'(1);
          free_head_next    = CNT_W'(h_idx);
          rsp_next.status   = STAT_OK;
        end
      end
      OP_GET: begin
        if (found && !(ref_mode && e_cnt == '0)) begin
          rsp_next.data_out = WORD_DATA_BITS'(e_data);
          rsp_next.status   = STAT_OK;
        end
      end
      OP_SET: begin
        if (found && !(ref_mode && e_cnt == '0)) begin
          wr_en           = 1'b1;
          wr_word         = {rd_word[WORD_W-1:TC_LO], h_data};
          rsp_next.status = STAT_OK;
        end
      end
      OP_ACQUIRE: begin
        if (counted) begin
          if (e_cnt == COUNT_MAX) begin
            rsp_next.status = STAT_SATURATED;
          end else begin
            wr_en             = 1'b1;
            wr_word           = {e_link, e_tag, e_cnt + INDEX_BITS'(1), e_data};
            rsp_next.data_out = WORD_DATA_BITS'(e_data);
            rsp_next.is_valid = 1'b1;
            rsp_next.status   = STAT_OK;
          end
        end
      end
      OP_RELEASE: begin
        if (counted) begin
          wr_en                   = 1'b1;
          rsp_next.previous_count = e_cnt;
          rsp_next.status         = STAT_OK;
          if (e_cnt == INDEX_BITS'(1)) begin
            // The last reference goes: the entry is freed as by dispose.
            wr_word         = {free_head, {HANDLE_BITS{1'b0}}, {DATA_WIDTH{1'b0}}};
            live_count_next = live_count - CNT_W'(1);
            free_head_next  = CNT_W'(h_idx);
          end else begin
            wr_word = {e_link, e_tag, e_cnt - INDEX_BITS'(1), e_data};
          end
        end
      end
      OP_CHECK: begin
        rsp_next.is_valid = found;
        rsp_next.status   = found ? STAT_OK : STAT_INVALID;
      end
      default: begin
        rsp_next.status = STAT_INVALID;
      end
    endcase

    rsp_next.used_entries = USED_BITS'(live_count_next);

    if (!fire) begin
      wr_en = 1'b0;
    end
  end

  // Bookkeeping and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_mode   <= 1'b0;
      next_tag   <= TAG_BITS'(1);
      free_head  <= '0;
      high_water <= '0;
      live_count <= '0;
    end else begin
      if (fire) begin
        free_head  <= free_head_next;
        high_water <= high_water_next;
        live_count <= live_count_next;
        next_tag   <= next_tag_next;
      end
      if (cfg_we) begin
        if (cfg_index == CFG_REF_MODE) begin
          ref_mode <= cfg_data[0];
        end else if (cfg_index == CFG_TAG_SEED) begin
          next_tag <= (cfg_data == '0) ? TAG_BITS'(1) : cfg_data;
        end
      end
    end
  end

  // Request hold register; payload only, no reset needed.
  always_ff @(posedge clk) begin
    if (req_take) begin
      req_q <= req;
    end
  end

  // Output register: loaded when a request finishes, emptied when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp <= rsp_next;
    end
  end

endmodule
